/* design/ets_pkg.sv */
// ----------------------------------------------------------------------------
// ets_pkg
// Token kinds and the result and queue entry formats shared by the scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

	typedef enum logic [4:0] {
		K_FLOAT   = 5'd0,
		K_INT     = 5'd1,
		K_CONST   = 5'd2,
		K_LABEL   = 5'd3,
		K_DIGIT   = 5'd4,
		K_OPEN    = 5'd5,
		K_CLOSE   = 5'd6,
		K_END     = 5'd7,
		K_BREAK   = 5'd8,
		K_ASSIGN  = 5'd9,
		K_ADD     = 5'd10,
		K_SUB     = 5'd11,
		K_MUL     = 5'd12,
		K_DIV     = 5'd13,
		K_ADDASG  = 5'd14,
		K_SUBASG  = 5'd15,
		K_MULASG  = 5'd16,
		K_DIVASG  = 5'd17,
		K_POS     = 5'd18,
		K_NEG     = 5'd19,
		K_COMMENT = 5'd20,
		K_DONE    = 5'd21,
		K_NONE    = 5'd22
	} ets_kind_t;

	// One result: either a text byte (kind zero) or a finished token (byte zero).
	typedef struct packed {
		logic      is_text;
		logic [7:0] text_byte;
		ets_kind_t token_kind;
	} ets_res_t;

	// All results caused by one request: one or two of them.
	typedef struct packed {
		logic     two;
		ets_res_t r0;
		ets_res_t r1;
	} ets_entry_t;

endpackage

/* design/ets_front.sv */
// ----------------------------------------------------------------------------
// ets_front
// Scanner FSM: classify one request per cycle unless q_full and queue its results.
// ----------------------------------------------------------------------------
module ets_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        ch,
	input  logic              q_full,
	output logic              q_push,
	output ets_pkg::ets_entry_t q_entry
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_LABEL,
		M_NUMBER,
		M_COMMENT,
		M_PEND
	} mode_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_STAR  = "*";
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_OPEN  = "(";
	localparam logic [7:0] CH_CLOSE = ")";
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_UNDER = "_";
	localparam logic [7:0] CH_F     = "f";
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// First label byte sits in the low byte.
	localparam logic [39:0] KW_INT   = {16'h0000, "tni"};
	localparam logic [39:0] KW_FLOAT = "taolf";
	localparam logic [39:0] KW_CONST = "tsnoc";

	mode_t             mode_q, nxt_mode;
	op_t               op_q, nxt_op;
	ets_pkg::ets_kind_t prev_q, nxt_prev;
	logic [39:0]       kw_q, nxt_kw;
	logic [2:0]        len_q, nxt_len;

	ets_pkg::ets_res_t e1a, e1b, e2;
	logic [1:0]        n1;
	logic              v2;
	logic              run_idle;
	ets_pkg::ets_kind_t p_idle;
	ets_pkg::ets_kind_t k1;
	logic              accept;

	function automatic ets_pkg::ets_res_t mk_text(input logic [7:0] c);
		ets_pkg::ets_res_t r;
		r.is_text    = 1'b1;
		r.text_byte  = c;
		r.token_kind = ets_pkg::K_FLOAT;
		return r;
	endfunction

	function automatic ets_pkg::ets_res_t mk_kind(input ets_pkg::ets_kind_t k);
		ets_pkg::ets_res_t r;
		r.is_text    = 1'b0;
		r.text_byte  = 8'h00;
		r.token_kind = k;
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic ets_pkg::ets_kind_t plain_kind(input op_t op);
		ets_pkg::ets_kind_t k;
		unique case (op)
			OP_ADD: k = ets_pkg::K_ADD;
			OP_SUB: k = ets_pkg::K_SUB;
			OP_MUL: k = ets_pkg::K_MUL;
			OP_DIV: k = ets_pkg::K_DIV;
		endcase
		return k;
	endfunction

	function automatic ets_pkg::ets_kind_t assign_kind(input op_t op);
		ets_pkg::ets_kind_t k;
		unique case (op)
			OP_ADD: k = ets_pkg::K_ADDASG;
			OP_SUB: k = ets_pkg::K_SUBASG;
			OP_MUL: k = ets_pkg::K_MULASG;
			OP_DIV: k = ets_pkg::K_DIVASG;
		endcase
		return k;
	endfunction

	// Keyword match on the buffered first five bytes.
	always_comb begin
		if (len_q == 3'd3 && kw_q == KW_INT) begin
			k1 = ets_pkg::K_INT;
		end else if (len_q == 3'd5 && kw_q == KW_FLOAT) begin
			k1 = ets_pkg::K_FLOAT;
		end else if (len_q == 3'd5 && kw_q == KW_CONST) begin
			k1 = ets_pkg::K_CONST;
		end else begin
			k1 = ets_pkg::K_LABEL;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		nxt_mode = mode_q;
		nxt_op   = op_q;
		nxt_prev = prev_q;
		nxt_kw   = kw_q;
		nxt_len  = len_q;
		e1a      = mk_kind(ets_pkg::K_FLOAT);
		e1b      = mk_kind(ets_pkg::K_FLOAT);
		e2       = mk_kind(ets_pkg::K_FLOAT);
		n1       = 2'd0;
		v2       = 1'b0;
		run_idle = 1'b0;
		p_idle   = prev_q;

		if (req_type) begin
			// End of source: flush what is being built, then done, then reset.
			unique case (mode_q)
				M_LABEL:   begin e1a = mk_kind(k1); n1 = 2'd1; end
				M_NUMBER:  begin e1a = mk_kind(ets_pkg::K_DIGIT); n1 = 2'd1; end
				M_COMMENT: begin e1a = mk_kind(ets_pkg::K_COMMENT); n1 = 2'd1; end
				M_PEND:    begin e1a = mk_kind(plain_kind(op_q)); n1 = 2'd1; end
				M_IDLE:    begin end
			endcase
			e2       = mk_kind(ets_pkg::K_DONE);
			v2       = 1'b1;
			nxt_mode = M_IDLE;
			nxt_op   = OP_ADD;
			nxt_prev = ets_pkg::K_NONE;
			nxt_kw   = '0;
			nxt_len  = '0;
		end else begin
			unique case (mode_q)
				M_LABEL: begin
					if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
						if (len_q < 3'd5) begin
							nxt_kw[{len_q, 3'b000} +: 8] = ch;
						end
						if (len_q < 3'd6) begin
							nxt_len = len_q + 3'd1;
						end
						e1a = mk_text(ch);
						n1  = 2'd1;
					end else begin
						e1a      = mk_kind(k1);
						n1       = 2'd1;
						nxt_prev = k1;
						nxt_mode = M_IDLE;
						run_idle = 1'b1;
						p_idle   = k1;
					end
				end
				M_NUMBER: begin
					if (is_digit(ch) || ch == CH_DOT) begin
						e1a = mk_text(ch);
						n1  = 2'd1;
					end else begin
						// A trailing f belongs to the number; eat it.
						e1a      = mk_kind(ets_pkg::K_DIGIT);
						n1       = 2'd1;
						nxt_prev = ets_pkg::K_DIGIT;
						nxt_mode = M_IDLE;
						run_idle = (ch != CH_F);
						p_idle   = ets_pkg::K_DIGIT;
					end
				end
				M_COMMENT: begin
					if (ch == CH_LF || ch == CH_CR) begin
						e1a      = mk_kind(ets_pkg::K_COMMENT);
						n1       = 2'd1;
						nxt_prev = ets_pkg::K_COMMENT;
						nxt_mode = M_IDLE;
					end else begin
						e1a = mk_text(ch);
						n1  = 2'd1;
					end
				end
				M_PEND: begin
					nxt_op = OP_ADD;
					if (op_q == OP_DIV && ch == CH_SLASH) begin
						e1a      = mk_text(CH_SLASH);
						e1b      = mk_text(CH_SLASH);
						n1       = 2'd2;
						nxt_mode = M_COMMENT;
					end else if (ch == CH_EQ) begin
						e1a      = mk_kind(assign_kind(op_q));
						n1       = 2'd1;
						nxt_prev = assign_kind(op_q);
						nxt_mode = M_IDLE;
					end else begin
						e1a      = mk_kind(plain_kind(op_q));
						n1       = 2'd1;
						nxt_prev = plain_kind(op_q);
						nxt_mode = M_IDLE;
						run_idle = 1'b1;
						p_idle   = plain_kind(op_q);
					end
				end
				M_IDLE: begin
					run_idle = 1'b1;
				end
			endcase

			// Scan a byte that starts something new.
			if (run_idle) begin
				if (is_space(ch)) begin
					// skip
				end else if (is_alpha(ch) || ch == CH_UNDER) begin
					nxt_mode = M_LABEL;
					nxt_kw   = {32'h0, ch};
					nxt_len  = 3'd1;
					e2       = mk_text(ch);
					v2       = 1'b1;
				end else if (is_digit(ch)) begin
					nxt_mode = M_NUMBER;
					e2       = mk_text(ch);
					v2       = 1'b1;
				end else if (ch == CH_PLUS || ch == CH_MINUS) begin
					case (p_idle) inside
						ets_pkg::K_LABEL, ets_pkg::K_DIGIT, ets_pkg::K_NONE,
						ets_pkg::K_CLOSE: begin
							nxt_mode = M_PEND;
							nxt_op   = (ch == CH_PLUS) ? OP_ADD : OP_SUB;
						end
						[ets_pkg::K_ADD:ets_pkg::K_DIV], ets_pkg::K_ASSIGN,
						[ets_pkg::K_ADDASG:ets_pkg::K_DIVASG], ets_pkg::K_OPEN,
						ets_pkg::K_BREAK: begin
							nxt_prev = (ch == CH_PLUS) ? ets_pkg::K_POS : ets_pkg::K_NEG;
							e2       = mk_kind(nxt_prev);
							v2       = 1'b1;
						end
						default: begin
							// drop the sign
						end
					endcase
				end else if (ch == CH_STAR || ch == CH_SLASH) begin
					nxt_mode = M_PEND;
					nxt_op   = (ch == CH_STAR) ? OP_MUL : OP_DIV;
				end else if (ch == CH_OPEN) begin
					nxt_prev = ets_pkg::K_OPEN;
					e2       = mk_kind(ets_pkg::K_OPEN);
					v2       = 1'b1;
				end else if (ch == CH_CLOSE) begin
					nxt_prev = ets_pkg::K_CLOSE;
					e2       = mk_kind(ets_pkg::K_CLOSE);
					v2       = 1'b1;
				end else if (ch == CH_EQ) begin
					nxt_prev = ets_pkg::K_ASSIGN;
					e2       = mk_kind(ets_pkg::K_ASSIGN);
					v2       = 1'b1;
				end else if (ch == CH_SEMI) begin
					nxt_prev = ets_pkg::K_END;
					e2       = mk_kind(ets_pkg::K_END);
					v2       = 1'b1;
				end else if (ch == CH_COMMA) begin
					nxt_prev = ets_pkg::K_BREAK;
					e2       = mk_kind(ets_pkg::K_BREAK);
					v2       = 1'b1;
				end
			end
		end
	end

	// Pack up to two results into one queue entry.
	always_comb begin
		q_entry.two = 1'b0;
		q_entry.r0  = e1a;
		q_entry.r1  = e1b;
		if (n1 == 2'd2) begin
			q_entry.two = 1'b1;
		end else if (n1 == 2'd1) begin
			q_entry.two = v2;
			q_entry.r1  = e2;
		end else begin
			q_entry.r0 = e2;
		end
	end

	assign q_push = accept && (n1 != 2'd0 || v2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			op_q   <= OP_ADD;
			prev_q <= ets_pkg::K_NONE;
			kw_q   <= '0;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			op_q   <= nxt_op;
			prev_q <= nxt_prev;
			kw_q   <= nxt_kw;
			len_q  <= nxt_len;
		end
	end

endmodule

/* design/ets_fifo.sv */
// ----------------------------------------------------------------------------
// ets_fifo
// Small register queue of result entries between the scanner and the output.
// ----------------------------------------------------------------------------
module ets_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ets_pkg::ets_entry_t wr_entry,
	output logic               full,
	input  logic               pop,
	output ets_pkg::ets_entry_t rd_entry,
	output logic               empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ets_pkg::ets_entry_t mem_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       count_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/ets_back.sv */
// ----------------------------------------------------------------------------
// ets_back
// Output side: unpack queue entries and send one result per cycle while out_ready.
// ----------------------------------------------------------------------------
module ets_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ets_pkg::ets_entry_t q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_text,
	output logic [7:0]         text_byte,
	output logic [4:0]         token_kind,
	output logic               last_of_run
);

	logic              out_valid_q;
	ets_pkg::ets_res_t out_res_q;
	logic              out_last_q;
	logic              hold_valid_q;
	ets_pkg::ets_res_t hold_res_q;
	logic              load;

	// The output register may take a new result when empty or being drained.
	assign load  = !out_valid_q || out_ready;
	assign q_pop = load && !hold_valid_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= !q_empty;
				hold_valid_q <= !q_empty && q_entry.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (hold_valid_q) begin
				out_res_q  <= hold_res_q;
				out_last_q <= 1'b1;
			end else if (!q_empty) begin
				out_res_q  <= q_entry.r0;
				out_last_q <= !q_entry.two;
				hold_res_q <= q_entry.r1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign is_text     = out_res_q.is_text;
	assign text_byte   = out_res_q.text_byte;
	assign token_kind  = out_res_q.token_kind;
	assign last_of_run = out_last_q;

endmodule

/* design/expression_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// expression_token_scanner_top
// Streaming lexer: one source byte or end-of-source mark per request, out come
// text bytes of labels, numbers and comments and the finished token kinds.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Handshake             Carries
//  ----------   ---------  --------------------  ------------------------------
//  request      in         in_valid / in_ready   req_type, ch
//  result       out        out_valid / out_ready is_text, text_byte,
//                                                token_kind, last_of_run
//
//  The scanner takes a request whenever the result queue has room, so requests
//  can arrive back to back. A request makes zero, one or two results; the
//  output register sends one result per cycle while out_ready is high. Reset is
//  asynchronous and takes effect at once; there is no clearing pass. A stall on
//  the output fills the queue and then drops in_ready; a gap on the input
//  simply leaves the output draining.
//
module expression_token_scanner_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_text,
	output logic [7:0] text_byte,
	output logic [4:0] token_kind,
	output logic       last_of_run
);

	// Entries between scanner and output side.
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	ets_pkg::ets_entry_t q_wr_entry;
	ets_pkg::ets_entry_t q_rd_entry;

	// Front: classify each byte, advance the scanner state, queue its results.
	ets_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.ch       (ch),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_wr_entry)
	);

	// Queue: decouple the scanner from output stalls.
	ets_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.empty    (q_empty)
	);

	// Back: send each queued result in order, marking the last of each request.
	ets_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_entry     (q_rd_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_text     (is_text),
		.text_byte   (text_byte),
		.token_kind  (token_kind),
		.last_of_run (last_of_run)
	);

endmodule

/* design/ets_checker.sv */
// ----------------------------------------------------------------------------
// ets_checker
// Port-level checks on the result channel of the scanner.
// ----------------------------------------------------------------------------
module ets_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_text,
	input logic [7:0] text_byte,
	input logic [4:0] token_kind,
	input logic       last_of_run
);

	// Hold a stalled result unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_text) &&
		$stable(text_byte) && $stable(token_kind) && $stable(last_of_run))
		else $error("stalled result changed");

	// Done is always the final result of its request and is never text.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_text && token_kind == ets_pkg::K_DONE |-> last_of_run)
		else $error("done not marked last");

	// Text results carry no kind; token results carry no byte.
	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_text |-> token_kind == ets_pkg::K_FLOAT)
		else $error("text result with nonzero kind");

	a_kind_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_text |-> text_byte == 8'h00 &&
		token_kind != ets_pkg::K_NONE)
		else $error("token result with byte or bad kind");

endmodule

bind expression_token_scanner_top ets_checker u_ets_checker (.*);
